/* rtl/core/hex_field_formatter_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef HEX_FIELD_FORMATTER_ASSERT_SVH
`define HEX_FIELD_FORMATTER_ASSERT_SVH

// Checked at every rising edge outside of reset.
`define HFF_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define HFF_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/hff_pkg.sv */
// ----------------------------------------------------------------------------
// hff_pkg
// Shared types, constants and the digit lookup of the hex field formatter.
// ----------------------------------------------------------------------------
package hff_pkg;

    // Largest width or precision honored; larger requests saturate here.
    localparam int MAX_FIELD = 64;
    // Bits of the spec fields and of the pad, zero and total character counts.
    localparam int CNT_W = 7;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;

    localparam logic [1:0] PAD_RIGHT = 2'd0;
    localparam logic [1:0] PAD_LEFT  = 2'd1;
    localparam logic [1:0] PAD_ZERO  = 2'd2;

    // One classified field, as the back end needs it.
    typedef struct packed {
        logic [31:0]      value;
        logic             upper;
        logic             pad_zero;
        logic [CNT_W-1:0] pre;
        logic [CNT_W-1:0] zeros;
        logic [3:0]       ndig;
        logic [CNT_W-1:0] post;
        logic [CNT_W-1:0] total;
    } t_desc;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {4'd0, nib};
        end else if (upper) begin
            ch = CH_UP_A + {4'd0, nib} - 8'd10;
        end else begin
            ch = CH_LOW_A + {4'd0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

/* rtl/core/hff_front.sv */
// ----------------------------------------------------------------------------
// hff_front
// Classifies one field spec into pad, zero and digit counts.
// ----------------------------------------------------------------------------
module hff_front import hff_pkg::*; (
    input  logic             i_accept,
    input  logic [31:0]      i_value,
    input  logic             i_upper_case,
    input  logic [CNT_W-1:0] i_field_width,
    input  logic [CNT_W-1:0] i_precision,
    input  logic             i_precision_given,
    input  logic [1:0]       i_pad_mode,
    output logic             o_push,
    output t_desc            o_desc
);

    logic [CNT_W-1:0] width;
    logic [CNT_W-1:0] prec;
    logic [3:0]       ndig;
    logic [CNT_W-1:0] ndig_w;
    logic [CNT_W-1:0] zeros;
    logic [CNT_W-1:0] body;
    logic [CNT_W-1:0] pad;
    logic             left;

    always_comb begin
        width = (i_field_width > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : i_field_width;
        if (!i_precision_given) begin
            prec = '0;
        end else begin
            prec = (i_precision > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : i_precision;
        end
    end

    // Digit count is the position of the highest nonzero nibble; a zero value
    // prints one digit unless an explicit precision of zero suppresses it.
    always_comb begin
        ndig = 4'd1;
        for (int k = 1; k < 8; k++) begin
            if (i_value[4*k +: 4] != 4'd0) begin
                ndig = 4'(k + 1);
            end
        end
        if (i_value == 32'd0 && i_precision_given && prec == '0) begin
            ndig = 4'd0;
        end
    end

    always_comb begin
        ndig_w = {{(CNT_W-4){1'b0}}, ndig};
        zeros  = (prec > ndig_w) ? prec - ndig_w : '0;
        body   = ndig_w + zeros;
        pad    = (width > body) ? width - body : '0;
        left   = (i_pad_mode == PAD_LEFT);
    end

    always_comb begin
        o_desc.value    = i_value;
        o_desc.upper    = i_upper_case;
        o_desc.pad_zero = (i_pad_mode == PAD_ZERO) && !i_precision_given;
        o_desc.pre      = left ? '0 : pad;
        o_desc.zeros    = zeros;
        o_desc.ndig     = ndig;
        o_desc.post     = left ? pad : '0;
        o_desc.total    = body + pad;
    end

    // An empty field produces no characters, so it never enters the queue.
    assign o_push = i_accept && (body + pad != '0);

endmodule

/* rtl/core/hff_queue.sv */
// ----------------------------------------------------------------------------
// hff_queue
// Two-entry queue of classified fields between front and back end.
// ----------------------------------------------------------------------------
module hff_queue import hff_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_desc o_desc
);

    t_desc      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_desc  = r_mem[r_rd];

endmodule

/* rtl/core/hff_back.sv */
// ----------------------------------------------------------------------------
// hff_back
// Walks one field through its pad, zero and digit runs, one character a cycle unless stalled.
// ----------------------------------------------------------------------------
module hff_back import hff_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_desc      i_desc,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_character,
    output logic       o_last
);

    logic             r_busy;
    logic [31:0]      r_value;
    logic             r_upper;
    logic             r_pad_zero;
    logic [CNT_W-1:0] r_pre;
    logic [CNT_W-1:0] r_zeros;
    logic [3:0]       r_dig;
    logic [CNT_W-1:0] r_post;
    logic [CNT_W-1:0] r_left;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;

    logic       advance;
    logic       finish;
    logic [2:0] nib_idx;
    logic [7:0] cur_char;

    assign advance = r_busy && (!r_out_valid || !i_stall);
    assign finish  = advance && (r_left == CNT_W'(1));
    assign o_pop   = !i_empty && (!r_busy || finish);
    assign nib_idx = 3'(r_dig - 4'd1);

    always_comb begin
        if (r_pre != '0) begin
            cur_char = r_pad_zero ? CH_ZERO : CH_SPACE;
        end else if (r_zeros != '0) begin
            cur_char = CH_ZERO;
        end else if (r_dig != 4'd0) begin
            cur_char = hex_char(r_value[{nib_idx, 2'b00} +: 4], r_upper);
        end else begin
            cur_char = CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_value    <= i_desc.value;
            r_upper    <= i_desc.upper;
            r_pad_zero <= i_desc.pad_zero;
            r_pre      <= i_desc.pre;
            r_zeros    <= i_desc.zeros;
            r_dig      <= i_desc.ndig;
            r_post     <= i_desc.post;
            r_left     <= i_desc.total;
        end else if (advance) begin
            r_left <= r_left - CNT_W'(1);
            if (r_pre != '0) begin
                r_pre <= r_pre - CNT_W'(1);
            end else if (r_zeros != '0) begin
                r_zeros <= r_zeros - CNT_W'(1);
            end else if (r_dig != 4'd0) begin
                r_dig <= r_dig - 4'd1;
            end else begin
                r_post <= r_post - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_char <= cur_char;
            r_out_last <= (r_left == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

endmodule

/* rtl/core/hex_field_formatter.sv */
// ----------------------------------------------------------------------------
// hex_field_formatter
// Prints a 32-bit value as printf-style hexadecimal text, one ASCII per word.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one field spec per word (value, case, width,
// precision and its given flag, pad mode) when i_valid is high and o_stall is
// low. The output channel gives one ASCII character per word when o_valid is
// high and i_stall is low; o_last marks the final character of each field.
// A field that prints nothing (zero value, given precision of zero, width of
// zero) produces no output word at all.
// Path: with the back end idle, an accepted spec goes into the queue, then into
// the back-end field registers, and its first character into the output register.
// Throughput: the character sequencer in the back end sends one character per
// cycle while the receiver does not stall; a field has max(width, digits plus
// precision zeros) characters, 1 to 64, and consecutive fields follow with no
// gap. A two-word queue lets the front accept specs while the back end prints.
// Reset: synchronous and active low; it empties the queue and drops any word
// in flight. When the receiver stalls, the current character holds on the
// outputs, the sequencer waits, and o_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module hex_field_formatter import hff_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [31:0]      i_value,
    input  logic             i_upper_case,
    input  logic [CNT_W-1:0] i_field_width,
    input  logic [CNT_W-1:0] i_precision,
    input  logic             i_precision_given,
    input  logic [1:0]       i_pad_mode,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_character,
    output logic             o_last
);

    logic  accept;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_desc front_desc;
    t_desc queue_desc;

    // The stall is the registered full flag of the queue, so it never
    // depends on the input valid.
    assign o_stall = full;
    assign accept  = i_valid && !full;

    // Front end: saturates the spec and works out every run length.
    hff_front u_front (
        .i_accept          (accept),
        .i_value           (i_value),
        .i_upper_case      (i_upper_case),
        .i_field_width     (i_field_width),
        .i_precision       (i_precision),
        .i_precision_given (i_precision_given),
        .i_pad_mode        (i_pad_mode),
        .o_push            (push),
        .o_desc            (front_desc)
    );

    hff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_desc  (queue_desc)
    );

    // Back end: loads the next field on the cycle the last character of the
    // current one enters the output register, so fields run back to back.
    hff_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_desc      (queue_desc),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

/* rtl/core/hff_checker.sv */
// ----------------------------------------------------------------------------
// hff_checker
// Port-level checks of the hex field formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "hex_field_formatter_assert.svh"

module hff_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_character,
    input logic       o_last
);

    // A stalled output word stays valid and unchanged.
    `HFF_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_character) && $stable(o_last), "output word changed while stalled")

    // Only pad characters and hex digits ever leave the block.
    `HFF_ASSERT_RUN(a_char_set, i_clk, i_rst_n, o_valid |-> (o_character == 8'h20) || (o_character >= 8'h30 && o_character <= 8'h39) || (o_character >= 8'h41 && o_character <= 8'h46) || (o_character >= 8'h61 && o_character <= 8'h66), "illegal character")

    // Reset empties the output stage and the queue.
    `HFF_ASSERT_ALL(a_reset_clear, i_clk, !i_rst_n |=> !o_valid && !o_stall, "state not cleared by reset")

    // The queue cannot fill before the first output word of the block exists.
    `HFF_ASSERT_RUN(a_full_needs_out, i_clk, i_rst_n, $rose(o_stall) |-> $past(o_valid) || o_valid || $past(o_stall, 2) == 1'b0, "queue full with idle back end")

endmodule

bind hex_field_formatter hff_checker u_hff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_character (o_character),
    .o_last      (o_last)
);
